// ===== rtl/core/tsct_pkg.sv =====
// Shared types and constants for the server connection table.
`timescale 1ns / 1ps
package tsct_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [2:0] OP_OPEN   = 3'd0;
  localparam logic [2:0] OP_LISTEN = 3'd1;
  localparam logic [2:0] OP_CLOSE  = 3'd2;
  localparam logic [2:0] OP_SEG    = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;
  localparam logic [2:0] OP_BAD    = 3'd7;

  localparam logic [2:0] SEG_SYN = 3'd0;
  localparam logic [2:0] SEG_FIN = 3'd2;

  localparam logic [1:0] KC_SYN   = 2'd0;
  localparam logic [1:0] KC_FIN   = 2'd1;
  localparam logic [1:0] KC_OTHER = 2'd2;

  localparam logic [1:0] ST_CLOSED    = 2'd0;
  localparam logic [1:0] ST_LISTENING = 2'd1;
  localparam logic [1:0] ST_CONNECTED = 2'd2;
  localparam logic [1:0] ST_CLOSEWAIT = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_REFUSED  = 2'd1;
  localparam logic [1:0] STATUS_NO_ENTRY = 2'd2;
  localparam logic [1:0] STATUS_IGNORED  = 2'd3;

  localparam logic REPLY_SYNACK = 1'b0;
  localparam logic REPLY_FINACK = 1'b1;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  kc;
    logic [3:0]  sock_index;
    logic [15:0] lport;
    logic [15:0] pport;
    logic [31:0] seq;
  } req_t;

endpackage

// ===== rtl/core/tsct_front.sv =====
// Request intake: decode func and segment kind, hold requests in a two-deep queue.
`timescale 1ns / 1ps
module tsct_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       func,
  input  logic [3:0]       sock_index,
  input  logic [15:0]      local_port,
  input  logic [15:0]      peer_port,
  input  logic [2:0]       seg_kind,
  input  logic [31:0]      seq_number,
  output logic             req_valid,
  output tsct_pkg::req_t   req,
  input  logic             req_ready
);
  import tsct_pkg::*;

  req_t       q [2];
  req_t       cls;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  always_comb begin
    cls.sock_index = sock_index;
    cls.lport      = local_port;
    cls.pport      = peer_port;
    cls.seq        = seq_number;
    case (func)
      OP_OPEN:   cls.op = OP_OPEN;
      OP_LISTEN: cls.op = OP_LISTEN;
      OP_CLOSE:  cls.op = OP_CLOSE;
      OP_SEG:    cls.op = OP_SEG;
      OP_TICK:   cls.op = OP_TICK;
      default:   cls.op = OP_BAD;
    endcase
    case (seg_kind)
      SEG_SYN: cls.kc = KC_SYN;
      SEG_FIN: cls.kc = KC_FIN;
      default: cls.kc = KC_OTHER;
    endcase
  end

  assign in_ready  = (count != 2'd2);
  assign req_valid = (count != 2'd0);
  assign req       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
  end

endmodule

// ===== rtl/core/tsct_back.sv =====
// Connection table: entry search, state update and registered result.
`timescale 1ns / 1ps
module tsct_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  tsct_pkg::req_t  req,
  output logic            req_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      status,
  output logic [3:0]      entry_index,
  output logic            send_reply,
  output logic            reply_kind,
  output logic [15:0]     reply_src_port,
  output logic [15:0]     reply_dst_port,
  output logic [31:0]     reply_seq,
  output logic            now_connected,
  output logic [4:0]      closed_count
);
  import tsct_pkg::*;

  localparam logic S_FIND = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;

  logic        entry_valid  [ENTRIES];
  logic [15:0] srv_port     [ENTRIES];
  logic [15:0] client_port  [ENTRIES];
  logic [1:0]  conn_state   [ENTRIES];
  logic [31:0] expected_seq [ENTRIES];

  logic             free_any;
  logic [IDX_W-1:0] free_idx;
  logic             match_any;
  logic [IDX_W-1:0] match_idx;
  logic [ENTRIES-1:0] cw_mask;
  logic             in_range;
  logic [IDX_W-1:0] sel_idx;
  logic             sel_found;

  logic [2:0]         p_op;
  logic [1:0]         p_kc;
  logic [3:0]         p_sock;
  logic [15:0]        p_lport;
  logic [15:0]        p_pport;
  logic [31:0]        p_seq;
  logic [IDX_W-1:0]   p_sel;
  logic               p_found;
  logic [ENTRIES-1:0] p_cw;

  logic        cur_valid;
  logic [1:0]  cur_state;
  logic [15:0] cur_sp;
  logic [15:0] cur_cp;

  logic        fire;
  logic        commit;
  logic        wr_open;
  logic        wr_listen;
  logic        wr_free;
  logic        wr_connect;
  logic        wr_cwait;
  logic        wr_tick;

  logic [1:0]       r_status;
  logic [3:0]       r_entry;
  logic             r_reply;
  logic             r_kind;
  logic [15:0]      r_src;
  logic [15:0]      r_dst;
  logic [31:0]      r_seq;
  logic             r_conn;
  logic [CNT_W-1:0] r_count;

  assign req_ready = (state == S_FIND);
  assign fire      = !out_valid || out_ready;
  assign commit    = (state == S_EXEC) && fire;

  always_comb begin
    free_any  = 1'b0;
    free_idx  = '0;
    match_any = 1'b0;
    match_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
      if (entry_valid[i] && srv_port[i] == req.lport) begin
        match_any = 1'b1;
        match_idx = IDX_W'(i);
      end
      cw_mask[i] = entry_valid[i] && (conn_state[i] == ST_CLOSEWAIT);
    end
    in_range = (32'(req.sock_index) < 32'(ENTRIES));
    case (req.op)
      OP_OPEN: begin
        sel_idx   = free_idx;
        sel_found = free_any;
      end
      OP_LISTEN, OP_CLOSE: begin
        sel_idx   = IDX_W'(req.sock_index);
        sel_found = in_range;
      end
      OP_SEG: begin
        sel_idx   = match_idx;
        sel_found = match_any;
      end
      default: begin
        sel_idx   = '0;
        sel_found = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FIND;
    end else if (state == S_FIND) begin
      if (req_valid) state <= S_EXEC;
    end else if (fire) begin
      state <= S_FIND;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIND && req_valid) begin
      p_op    <= req.op;
      p_kc    <= req.kc;
      p_sock  <= req.sock_index;
      p_lport <= req.lport;
      p_pport <= req.pport;
      p_seq   <= req.seq;
      p_sel   <= sel_idx;
      p_found <= sel_found;
      p_cw    <= cw_mask;
    end
  end

  always_comb begin
    cur_valid  = entry_valid[p_sel];
    cur_state  = conn_state[p_sel];
    cur_sp     = srv_port[p_sel];
    cur_cp     = client_port[p_sel];
    wr_open    = 1'b0;
    wr_listen  = 1'b0;
    wr_free    = 1'b0;
    wr_connect = 1'b0;
    wr_cwait   = 1'b0;
    wr_tick    = 1'b0;
    r_status   = STATUS_OK;
    r_entry    = 4'd0;
    r_reply    = 1'b0;
    r_kind     = REPLY_SYNACK;
    r_src      = 16'd0;
    r_dst      = 16'd0;
    r_seq      = 32'd0;
    r_conn     = 1'b0;
    r_count    = '0;
    case (p_op)
      OP_OPEN: begin
        if (!p_found) begin
          r_status = STATUS_REFUSED;
        end else begin
          wr_open = 1'b1;
          r_entry = 4'(p_sel);
        end
      end
      OP_LISTEN, OP_CLOSE: begin
        r_entry = p_sock;
        if (!p_found || !cur_valid) begin
          r_status = STATUS_NO_ENTRY;
        end else if (p_op == OP_LISTEN) begin
          wr_listen = 1'b1;
        end else if (cur_state == ST_CLOSED) begin
          wr_free = 1'b1;
        end else begin
          r_status = STATUS_REFUSED;
        end
      end
      OP_SEG: begin
        if (!p_found) begin
          r_status = STATUS_NO_ENTRY;
        end else begin
          r_entry  = 4'(p_sel);
          r_status = STATUS_IGNORED;
          r_src    = cur_sp;
          r_dst    = cur_cp;
          if (cur_state == ST_LISTENING && p_kc == KC_SYN) begin
            wr_connect = 1'b1;
            r_reply    = 1'b1;
            r_conn     = 1'b1;
            r_dst      = p_pport;
          end else if (cur_state == ST_CONNECTED && p_kc == KC_FIN) begin
            wr_cwait = 1'b1;
            r_reply  = 1'b1;
            r_kind   = REPLY_FINACK;
          end else if (cur_state == ST_CONNECTED && p_kc == KC_SYN) begin
            r_reply = 1'b1;
          end else if (cur_state == ST_CLOSEWAIT && p_kc == KC_FIN) begin
            r_reply = 1'b1;
            r_kind  = REPLY_FINACK;
          end
          if (r_reply) begin
            r_status = STATUS_OK;
            r_seq    = p_seq;
          end else begin
            r_src = 16'd0;
            r_dst = 16'd0;
          end
        end
      end
      OP_TICK: begin
        wr_tick = 1'b1;
        for (int i = 0; i < ENTRIES; i++) begin
          r_count = r_count + CNT_W'(p_cw[i]);
        end
      end
      default: begin
        r_status = STATUS_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        entry_valid[i] <= 1'b0;
      end
    end else if (commit) begin
      if (wr_open) entry_valid[p_sel] <= 1'b1;
      if (wr_free) entry_valid[p_sel] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (wr_open) begin
        srv_port[p_sel]     <= p_lport;
        client_port[p_sel]  <= 16'd0;
        conn_state[p_sel]   <= ST_CLOSED;
        expected_seq[p_sel] <= 32'd0;
      end
      if (wr_listen) conn_state[p_sel] <= ST_LISTENING;
      if (wr_connect) begin
        client_port[p_sel]  <= p_pport;
        expected_seq[p_sel] <= p_seq + 32'd1;
        conn_state[p_sel]   <= ST_CONNECTED;
      end
      if (wr_cwait) conn_state[p_sel] <= ST_CLOSEWAIT;
      if (wr_tick) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (p_cw[i]) conn_state[i] <= ST_CLOSED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status         <= r_status;
      entry_index    <= r_entry;
      send_reply     <= r_reply;
      reply_kind     <= r_kind;
      reply_src_port <= r_src;
      reply_dst_port <= r_dst;
      reply_seq      <= r_seq;
      now_connected  <= r_conn;
      closed_count   <= 5'(r_count);
    end
  end

endmodule

// ===== rtl/core/transport_server_connection_table.sv =====
// A request is held in the request queue, captured in the find state, and its result is registered
// when the execute state commits; the back end takes no new request until it is back in the find state.
// A two-deep request queue keeps intake going while a result waits on out_ready.
// Reset clears all entry valid bits at once; no clearing pass follows.
`timescale 1ns / 1ps
module transport_server_connection_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [3:0]  sock_index,
  input  logic [15:0] local_port,
  input  logic [15:0] peer_port,
  input  logic [2:0]  seg_kind,
  input  logic [31:0] seq_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [3:0]  entry_index,
  output logic        send_reply,
  output logic        reply_kind,
  output logic [15:0] reply_src_port,
  output logic [15:0] reply_dst_port,
  output logic [31:0] reply_seq,
  output logic        now_connected,
  output logic [4:0]  closed_count
);
  import tsct_pkg::*;

  logic req_valid;
  logic req_ready;
  req_t req;

  tsct_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .sock_index (sock_index),
    .local_port (local_port),
    .peer_port  (peer_port),
    .seg_kind   (seg_kind),
    .seq_number (seq_number),
    .req_valid  (req_valid),
    .req        (req),
    .req_ready  (req_ready)
  );

  tsct_back u_back (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req            (req),
    .req_ready      (req_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .entry_index    (entry_index),
    .send_reply     (send_reply),
    .reply_kind     (reply_kind),
    .reply_src_port (reply_src_port),
    .reply_dst_port (reply_dst_port),
    .reply_seq      (reply_seq),
    .now_connected  (now_connected),
    .closed_count   (closed_count)
  );

endmodule

// ===== test/tb_transport_server_connection_table.sv =====
// Testbench for transport_server_connection_table: random and directed requests, scoreboard check.
`timescale 1ns / 1ps
module tb_transport_server_connection_table;
  import tsct_pkg::*;

  localparam logic [2:0] OP_SPARE5   = 3'd5;
  localparam logic [2:0] OP_SPARE6   = 3'd6;
  localparam logic [2:0] SEG_SYNACK  = 3'd1;
  localparam logic [2:0] SEG_FINACK  = 3'd3;
  localparam logic [2:0] SEG_DATA    = 3'd4;
  localparam logic [2:0] SEG_UNKNOWN = 3'd7;
  localparam int RANDOM_ITEMS = 700;
  localparam int PHASE_ITEMS  = 100;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  entry_index;
    logic        send_reply;
    logic        reply_kind;
    logic [15:0] reply_src_port;
    logic [15:0] reply_dst_port;
    logic [31:0] reply_seq;
    logic        now_connected;
    logic [4:0]  closed_count;
  } response_t;

  class conn_table_scoreboard;
    bit          used [ENTRIES];
    logic [15:0] srv_port [ENTRIES];
    logic [15:0] clnt_port [ENTRIES];
    logic [1:0]  conn_st [ENTRIES];
    logic [31:0] next_seq [ENTRIES];
    response_t   pending_responses [$];
    int mismatches;
    int requests_seen;
    int results_seen;
    int replies;
    int connects;
    int full_refusals;
    int tick_closes;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        used[i] = 1'b0;
      end
      mismatches = 0;
      requests_seen = 0;
      results_seen = 0;
      replies = 0;
      connects = 0;
      full_refusals = 0;
      tick_closes = 0;
    endfunction

    function int outstanding();
      return pending_responses.size();
    endfunction

    function int pick_entry(bit any_state, logic [1:0] want);
      int cand [$];
      for (int i = 0; i < ENTRIES; i++) begin
        if (used[i] && (any_state || conn_st[i] == want)) cand.push_back(i);
      end
      if (cand.size() == 0) return -1;
      return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    function response_t compute_response(logic [2:0] op, logic [3:0] slot,
                                         logic [15:0] dst_port, logic [15:0] from_port,
                                         logic [2:0] kind, logic [31:0] seq);
      response_t r;
      int hit;
      int count;
      r = '0;
      hit = -1;
      count = 0;
      case (op)
        OP_OPEN: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && !used[i]) hit = i;
          end
          if (hit < 0) begin
            r.status = STATUS_REFUSED;
            full_refusals++;
          end else begin
            used[hit] = 1'b1;
            srv_port[hit] = dst_port;
            clnt_port[hit] = 16'h0000;
            conn_st[hit] = ST_CLOSED;
            next_seq[hit] = 32'h0;
            r.entry_index = 4'(hit);
          end
        end
        OP_LISTEN, OP_CLOSE: begin
          r.entry_index = slot;
          if (int'(slot) >= ENTRIES || !used[slot]) begin
            r.status = STATUS_NO_ENTRY;
          end else if (op == OP_LISTEN) begin
            conn_st[slot] = ST_LISTENING;
          end else if (conn_st[slot] == ST_CLOSED) begin
            used[slot] = 1'b0;
          end else begin
            r.status = STATUS_REFUSED;
          end
        end
        OP_SEG: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (hit < 0 && used[i] && srv_port[i] == dst_port) hit = i;
          end
          if (hit < 0) begin
            r.status = STATUS_NO_ENTRY;
          end else begin
            r.entry_index = 4'(hit);
            r.status = STATUS_IGNORED;
            if (conn_st[hit] == ST_LISTENING && kind == SEG_SYN) begin
              clnt_port[hit] = from_port;
              next_seq[hit] = seq + 32'd1;
              conn_st[hit] = ST_CONNECTED;
              r.status = STATUS_OK;
              r.send_reply = 1'b1;
              r.reply_kind = REPLY_SYNACK;
              r.now_connected = 1'b1;
              connects++;
            end else if (conn_st[hit] == ST_CONNECTED && kind == SEG_FIN) begin
              conn_st[hit] = ST_CLOSEWAIT;
              r.status = STATUS_OK;
              r.send_reply = 1'b1;
              r.reply_kind = REPLY_FINACK;
            end else if (conn_st[hit] == ST_CONNECTED && kind == SEG_SYN) begin
              r.status = STATUS_OK;
              r.send_reply = 1'b1;
              r.reply_kind = REPLY_SYNACK;
            end else if (conn_st[hit] == ST_CLOSEWAIT && kind == SEG_FIN) begin
              r.status = STATUS_OK;
              r.send_reply = 1'b1;
              r.reply_kind = REPLY_FINACK;
            end
            if (r.send_reply) begin
              r.reply_src_port = srv_port[hit];
              r.reply_dst_port = clnt_port[hit];
              r.reply_seq = seq;
              replies++;
            end
          end
        end
        OP_TICK: begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (used[i] && conn_st[i] == ST_CLOSEWAIT) begin
              conn_st[i] = ST_CLOSED;
              count++;
            end
          end
          r.closed_count = 5'(count);
          tick_closes += count;
        end
        default: begin
          r.status = STATUS_IGNORED;
        end
      endcase
      return r;
    endfunction

    function void note_request(logic [2:0] op, logic [3:0] slot, logic [15:0] dst_port,
                               logic [15:0] from_port, logic [2:0] kind, logic [31:0] seq);
      pending_responses.push_back(compute_response(op, slot, dst_port, from_port, kind, seq));
      requests_seen++;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: %s expected 0x%0h, got 0x%0h", results_seen, name, want, got);
      end
    endfunction

    function void check_result(response_t got);
      response_t want;
      if (pending_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with no request outstanding: %p", got);
        return;
      end
      want = pending_responses.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("entry_index", 32'(want.entry_index), 32'(got.entry_index));
      compare_field("send_reply", 32'(want.send_reply), 32'(got.send_reply));
      compare_field("reply_kind", 32'(want.reply_kind), 32'(got.reply_kind));
      compare_field("reply_src_port", 32'(want.reply_src_port), 32'(got.reply_src_port));
      compare_field("reply_dst_port", 32'(want.reply_dst_port), 32'(got.reply_dst_port));
      compare_field("reply_seq", want.reply_seq, got.reply_seq);
      compare_field("now_connected", 32'(want.now_connected), 32'(got.now_connected));
      compare_field("closed_count", 32'(want.closed_count), 32'(got.closed_count));
      results_seen++;
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  func = '0;
  logic [3:0]  sock_index = '0;
  logic [15:0] local_port = '0;
  logic [15:0] peer_port = '0;
  logic [2:0]  seg_kind = '0;
  logic [31:0] seq_number = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [3:0]  entry_index;
  logic        send_reply;
  logic        reply_kind;
  logic [15:0] reply_src_port;
  logic [15:0] reply_dst_port;
  logic [31:0] reply_seq;
  logic        now_connected;
  logic [4:0]  closed_count;

  conn_table_scoreboard sb = new();
  response_t observed;
  int ready_mode = 0;
  int ready_hold = 0;

  transport_server_connection_table i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .sock_index     (sock_index),
    .local_port     (local_port),
    .peer_port      (peer_port),
    .seg_kind       (seg_kind),
    .seq_number     (seq_number),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .entry_index    (entry_index),
    .send_reply     (send_reply),
    .reply_kind     (reply_kind),
    .reply_src_port (reply_src_port),
    .reply_dst_port (reply_dst_port),
    .reply_seq      (reply_seq),
    .now_connected  (now_connected),
    .closed_count   (closed_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_hold <= $urandom_range(32, 256);
    end else begin
      ready_hold <= ready_hold - 1;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= (ready_hold % 4 != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      observed.status = status;
      observed.entry_index = entry_index;
      observed.send_reply = send_reply;
      observed.reply_kind = reply_kind;
      observed.reply_src_port = reply_src_port;
      observed.reply_dst_port = reply_dst_port;
      observed.reply_seq = reply_seq;
      observed.now_connected = now_connected;
      observed.closed_count = closed_count;
      sb.check_result(observed);
    end
  end

  task automatic send_request(input logic [2:0] op, input logic [3:0] slot,
                              input logic [15:0] dst_port, input logic [15:0] from_port,
                              input logic [2:0] kind, input logic [31:0] seq);
    in_valid <= 1'b1;
    func <= op;
    sock_index <= slot;
    local_port <= dst_port;
    peer_port <= from_port;
    seg_kind <= kind;
    seq_number <= seq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(op, slot, dst_port, from_port, kind, seq);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    int n;
    int r;
    int sel;
    int pick;
    int burst_left;
    bit drain;
    logic [2:0]  f;
    logic [2:0]  k;
    logic [3:0]  idx;
    logic [15:0] lp;
    logic [15:0] pp;
    logic [31:0] sq;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_request(OP_OPEN, 4'hF, 16'h0000, 16'hFFFF, SEG_UNKNOWN, 32'hFFFF_FFFF);
    send_request(OP_OPEN, 4'h0, 16'hFFFF, 16'h0000, SEG_SYN, 32'h0000_0000);
    send_request(OP_LISTEN, 4'h0, 16'h0000, 16'h0000, SEG_SYN, 32'h0);
    send_request(OP_SEG, 4'h0, 16'h0000, 16'hFFFF, SEG_SYN, 32'hFFFF_FFFF);
    send_request(OP_SEG, 4'h0, 16'h0000, 16'h1234, SEG_SYN, 32'h0000_0000);
    send_request(OP_SEG, 4'h0, 16'h0000, 16'h0000, SEG_DATA, 32'h0000_0005);
    send_request(OP_CLOSE, 4'h0, 16'h0000, 16'h0000, SEG_SYN, 32'h0);
    send_request(OP_SEG, 4'h0, 16'h0000, 16'h0000, SEG_FIN, 32'h8000_0000);
    send_request(OP_SEG, 4'h0, 16'h0000, 16'h0000, SEG_FIN, 32'h0000_0001);
    send_request(OP_SEG, 4'h0, 16'h0000, 16'h0000, SEG_SYNACK, 32'h0000_0002);
    send_request(OP_TICK, 4'h0, 16'h0000, 16'h0000, SEG_SYN, 32'h0);
    send_request(OP_SEG, 4'h0, 16'h0000, 16'h0000, SEG_SYN, 32'h0000_0003);
    send_request(OP_CLOSE, 4'h0, 16'h0000, 16'h0000, SEG_SYN, 32'h0);
    send_request(OP_LISTEN, 4'h0, 16'h0000, 16'h0000, SEG_SYN, 32'h0);
    send_request(OP_CLOSE, 4'hF, 16'h0000, 16'h0000, SEG_SYN, 32'h0);
    send_request(OP_SEG, 4'h0, 16'hABCD, 16'h0001, SEG_SYN, 32'h0000_0004);
    send_request(OP_LISTEN, 4'h1, 16'h0000, 16'h0000, SEG_SYN, 32'h0);
    send_request(OP_SEG, 4'h0, 16'hFFFF, 16'h0000, SEG_UNKNOWN, 32'h0000_0006);
    send_request(OP_SEG, 4'h0, 16'hFFFF, 16'hFFFF, SEG_FINACK, 32'h0000_0007);
    send_request(OP_SEG, 4'h0, 16'hFFFF, 16'hFFFF, SEG_FIN, 32'h0000_0008);
    send_request(OP_SPARE5, 4'hF, 16'hFFFF, 16'hFFFF, SEG_UNKNOWN, 32'hFFFF_FFFF);
    send_request(OP_SPARE6, 4'h0, 16'h0000, 16'h0000, SEG_SYN, 32'h0);
    send_request(OP_BAD, 4'hA, 16'h5A5A, 16'hA5A5, SEG_FINACK, 32'h5A5A_A5A5);

    burst_left = $urandom_range(1, 24);
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n != 0 && n % PHASE_ITEMS == 0 && sb.outstanding() != 0) begin
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
      end
      drain = ((n / PHASE_ITEMS) % 2) == 1;
      f = 3'($urandom);
      idx = 4'($urandom);
      lp = 16'($urandom);
      pp = 16'($urandom);
      k = 3'($urandom);
      sq = $urandom;
      r = $urandom_range(0, 99);
      if (r < (drain ? 5 : 25)) begin
        f = OP_OPEN;
        case ($urandom_range(0, 4))
          0: lp = 16'h0000;
          1: lp = 16'hFFFF;
          2: lp = 16'h0050;
          default: ;
        endcase
      end else if (r < (drain ? 15 : 40)) begin
        f = OP_LISTEN;
        pick = sb.pick_entry(1'b1, ST_CLOSED);
        if (pick >= 0 && $urandom_range(0, 4) != 0) idx = 4'(pick);
      end else if (r < (drain ? 40 : 45)) begin
        f = OP_CLOSE;
        pick = sb.pick_entry(1'b0, ST_CLOSED);
        if (pick < 0) pick = sb.pick_entry(1'b1, ST_CLOSED);
        if (pick >= 0 && $urandom_range(0, 4) != 0) idx = 4'(pick);
      end else if (r < (drain ? 75 : 85)) begin
        f = OP_SEG;
        pick = sb.pick_entry(1'b1, ST_CLOSED);
        if (pick >= 0 && $urandom_range(0, 4) != 0) lp = sb.srv_port[pick];
        sel = $urandom_range(0, 9);
        if (sel < 4) k = SEG_SYN;
        else if (sel < 7) k = SEG_FIN;
      end else if (r < (drain ? 90 : 93)) begin
        f = OP_TICK;
      end
      send_request(f, idx, lp, pp, k, sq);
      burst_left--;
      if (burst_left == 0) begin
        idle_cycles($urandom_range(0, 6));
        burst_left = $urandom_range(1, 24);
      end
    end

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d requests and %0d results; %0d replies, %0d connections made",
             sb.requests_seen, sb.results_seen, sb.replies, sb.connects);
    $display("%0d opens refused on a full table, %0d entries closed by ticks, %0d mismatches",
             sb.full_refusals, sb.tick_closes, sb.mismatches);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tsct_pkg.sv
rtl/core/tsct_front.sv
rtl/core/tsct_back.sv
rtl/core/transport_server_connection_table.sv
test/tb_transport_server_connection_table.sv
